### sv/lpd_pkg.sv
package lpd_pkg;

    localparam logic [7:0]  TYPE_PACKET = 8'h02;
    localparam logic [7:0]  TYPE_KEY    = 8'h03;
    localparam logic [26:0] LIMIT_CAP   = 27'd67108864;
    localparam logic [31:0] MIN_PACKET  = 32'd30;

    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 27;

    localparam logic [CFG_INDEX_W-1:0] CFG_STREAM_COUNT = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_MAX_LENGTH   = 2'd1;

    typedef enum logic [2:0] {
        PH_LEN,
        PH_TYPE,
        PH_FIELDS,
        PH_PAYLOAD,
        PH_SKIP,
        PH_DRAIN
    } phase_t;

    typedef enum logic [1:0] {
        RK_HEADER  = 2'd0,
        RK_PAYLOAD = 2'd1,
        RK_STATUS  = 2'd2
    } rkind_t;

    typedef enum logic [1:0] {
        ST_NONE    = 2'd0,
        ST_EOS     = 2'd1,
        ST_BAD_LEN = 2'd2,
        ST_INVALID = 2'd3
    } status_t;

    typedef struct packed {
        logic [7:0]  stream_count;
        logic [26:0] max_length;
    } cfg_t;

    typedef struct packed {
        rkind_t             result_kind;
        status_t            status;
        logic [7:0]         stream_id;
        logic signed [63:0] pts;
        logic signed [63:0] dts;
        logic signed [63:0] duration;
        logic               is_key;
        logic [25:0]        payload_size;
        logic [7:0]         payload_byte;
        logic               last;
    } result_t;

endpackage

### sv/lpd_parser.sv
module lpd_parser (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            step,
    input  logic            kind,
    input  logic [7:0]      data_byte,
    input  lpd_pkg::cfg_t   cfg,
    output logic            res_valid,
    output lpd_pkg::result_t res
);

    lpd_pkg::phase_t phase_reg, phase_next;
    logic        halted_reg, halted_next;
    logic [31:0] len_reg, len_next;
    logic [26:0] pos_reg, pos_next;
    logic        key_reg, key_next;
    logic [7:0]  stream_reg, stream_next;
    logic [63:0] pts_reg, pts_next;
    logic [63:0] dts_reg, dts_next;
    logic [63:0] dur_reg, dur_next;
    logic [31:0] size_reg, size_next;

    logic        live;
    logic [31:0] len_shift;
    logic [31:0] size_shift;
    logic [26:0] pos_inc;
    logic [26:0] limit;
    logic        len_bad;
    logic        is_pkt;
    logic        end_msg;
    logic        fld_bad;
    logic        pay_last;
    logic        short_pkt;

    assign live       = step && !halted_reg;
    assign len_shift  = {len_reg[23:0], data_byte};
    assign size_shift = {size_reg[23:0], data_byte};
    assign pos_inc    = pos_reg + 27'd1;
    assign limit      = (cfg.max_length > lpd_pkg::LIMIT_CAP) ? lpd_pkg::LIMIT_CAP
                                                                : cfg.max_length;
    assign len_bad    = (len_shift == 32'd0) || (len_shift > {5'b0, limit});
    assign is_pkt     = (data_byte == lpd_pkg::TYPE_PACKET) || (data_byte == lpd_pkg::TYPE_KEY);
    assign end_msg    = ({5'b0, pos_reg} + 32'd1) >= len_reg;
    assign fld_bad    = (size_shift > (len_reg - lpd_pkg::MIN_PACKET))
                        || (stream_reg >= cfg.stream_count);
    assign pay_last   = ({5'b0, pos_reg} - 32'd29) >= size_reg;
    assign short_pkt  = len_reg < lpd_pkg::MIN_PACKET;

    // next state
    always_comb
    begin
        phase_next  = phase_reg;
        halted_next = halted_reg;
        if (live) begin
            if (kind) begin
                halted_next = 1'b1;
            end else begin
                unique case (phase_reg)
                    lpd_pkg::PH_LEN:
                    begin
                        if (pos_reg == 27'd3) begin
                            if (len_bad) halted_next = 1'b1;
                            else         phase_next  = lpd_pkg::PH_TYPE;
                        end
                    end
                    lpd_pkg::PH_TYPE:
                    begin
                        if (!is_pkt) begin
                            phase_next = end_msg ? lpd_pkg::PH_LEN : lpd_pkg::PH_SKIP;
                        end else if (short_pkt) begin
                            if (len_reg == 32'd1) halted_next = 1'b1;
                            else                  phase_next  = lpd_pkg::PH_DRAIN;
                        end else begin
                            phase_next = lpd_pkg::PH_FIELDS;
                        end
                    end
                    lpd_pkg::PH_FIELDS:
                    begin
                        if (pos_reg == 27'd29) begin
                            if (fld_bad) begin
                                if (len_reg == lpd_pkg::MIN_PACKET) halted_next = 1'b1;
                                else phase_next = lpd_pkg::PH_DRAIN;
                            end else if (end_msg) begin
                                phase_next = lpd_pkg::PH_LEN;
                            end else if (size_shift == 32'd0) begin
                                phase_next = lpd_pkg::PH_SKIP;
                            end else begin
                                phase_next = lpd_pkg::PH_PAYLOAD;
                            end
                        end
                    end
                    lpd_pkg::PH_PAYLOAD:
                    begin
                        if (end_msg)       phase_next = lpd_pkg::PH_LEN;
                        else if (pay_last) phase_next = lpd_pkg::PH_SKIP;
                    end
                    lpd_pkg::PH_SKIP:
                    begin
                        if (end_msg) phase_next = lpd_pkg::PH_LEN;
                    end
                    lpd_pkg::PH_DRAIN:
                    begin
                        if (end_msg) halted_next = 1'b1;
                    end
                    default:
                    begin
                        phase_next = lpd_pkg::PH_LEN;
                    end
                endcase
            end
        end
    end

    // datapath
    always_comb
    begin
        len_next    = len_reg;
        pos_next    = pos_reg;
        key_next    = key_reg;
        stream_next = stream_reg;
        pts_next    = pts_reg;
        dts_next    = dts_reg;
        dur_next    = dur_reg;
        size_next   = size_reg;
        if (live && !kind) begin
            case (phase_reg)
                lpd_pkg::PH_LEN:
                begin
                    len_next = len_shift;
                    pos_next = (pos_reg == 27'd3) ? 27'd0 : pos_inc;
                end
                lpd_pkg::PH_TYPE:
                begin
                    key_next = (data_byte == lpd_pkg::TYPE_KEY);
                    pos_next = pos_inc;
                    if (!is_pkt && end_msg) begin
                        len_next = 32'd0;
                        pos_next = 27'd0;
                    end
                end
                lpd_pkg::PH_FIELDS:
                begin
                    if (pos_reg == 27'd1)       stream_next = data_byte;
                    else if (pos_reg <= 27'd9)  pts_next = {pts_reg[55:0], data_byte};
                    else if (pos_reg <= 27'd17) dts_next = {dts_reg[55:0], data_byte};
                    else if (pos_reg <= 27'd25) dur_next = {dur_reg[55:0], data_byte};
                    else                        size_next = size_shift;
                    pos_next = pos_inc;
                    if (pos_reg == 27'd29 && !fld_bad && end_msg) begin
                        len_next = 32'd0;
                        pos_next = 27'd0;
                    end
                end
                lpd_pkg::PH_PAYLOAD, lpd_pkg::PH_SKIP:
                begin
                    pos_next = pos_inc;
                    if (end_msg) begin
                        len_next = 32'd0;
                        pos_next = 27'd0;
                    end
                end
                lpd_pkg::PH_DRAIN:
                begin
                    pos_next = pos_inc;
                end
                default:
                begin
                    pos_next = pos_reg;
                end
            endcase
        end
    end

    // result
    always_comb
    begin
        res_valid = 1'b0;
        res       = '0;
        if (live) begin
            if (kind) begin
                res_valid       = 1'b1;
                res.result_kind = lpd_pkg::RK_STATUS;
                res.status      = lpd_pkg::ST_EOS;
                res.last        = 1'b1;
            end else begin
                case (phase_reg)
                    lpd_pkg::PH_LEN:
                    begin
                        if (pos_reg == 27'd3 && len_bad) begin
                            res_valid       = 1'b1;
                            res.result_kind = lpd_pkg::RK_STATUS;
                            res.status      = lpd_pkg::ST_BAD_LEN;
                            res.last        = 1'b1;
                        end
                    end
                    lpd_pkg::PH_TYPE:
                    begin
                        if (is_pkt && len_reg == 32'd1) begin
                            res_valid       = 1'b1;
                            res.result_kind = lpd_pkg::RK_STATUS;
                            res.status      = lpd_pkg::ST_INVALID;
                            res.last        = 1'b1;
                        end
                    end
                    lpd_pkg::PH_FIELDS:
                    begin
                        if (pos_reg == 27'd29) begin
                            if (fld_bad) begin
                                if (len_reg == lpd_pkg::MIN_PACKET) begin
                                    res_valid       = 1'b1;
                                    res.result_kind = lpd_pkg::RK_STATUS;
                                    res.status      = lpd_pkg::ST_INVALID;
                                    res.last        = 1'b1;
                                end
                            end else begin
                                res_valid          = 1'b1;
                                res.result_kind    = lpd_pkg::RK_HEADER;
                                res.stream_id      = stream_reg;
                                res.pts            = pts_reg;
                                res.dts            = dts_reg;
                                res.duration       = dur_reg;
                                res.is_key         = key_reg;
                                res.payload_size   = size_shift[25:0];
                                res.last           = (size_shift == 32'd0);
                            end
                        end
                    end
                    lpd_pkg::PH_PAYLOAD:
                    begin
                        res_valid        = 1'b1;
                        res.result_kind  = lpd_pkg::RK_PAYLOAD;
                        res.payload_byte = data_byte;
                        res.last         = pay_last;
                    end
                    lpd_pkg::PH_DRAIN:
                    begin
                        if (end_msg) begin
                            res_valid       = 1'b1;
                            res.result_kind = lpd_pkg::RK_STATUS;
                            res.status      = lpd_pkg::ST_INVALID;
                            res.last        = 1'b1;
                        end
                    end
                    default:
                    begin
                        res_valid = 1'b0;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            phase_reg  <= lpd_pkg::PH_LEN;
            halted_reg <= 1'b0;
            len_reg    <= '0;
            pos_reg    <= '0;
            key_reg    <= 1'b0;
            stream_reg <= '0;
            pts_reg    <= '0;
            dts_reg    <= '0;
            dur_reg    <= '0;
            size_reg   <= '0;
        end else begin
            phase_reg  <= phase_next;
            halted_reg <= halted_next;
            len_reg    <= len_next;
            pos_reg    <= pos_next;
            key_reg    <= key_next;
            stream_reg <= stream_next;
            pts_reg    <= pts_next;
            dts_reg    <= dts_next;
            dur_reg    <= dur_next;
            size_reg   <= size_next;
        end
    end

endmodule

### sv/length_prefixed_packet_deframer_core.sv
// Length-prefixed packet deframer. Takes stream bytes on the input channel
// (kind 1 marks end of stream) and gives packet headers, payload bytes and
// status words on the output channel, in the cycle after the byte that causes
// them, from an output register. Sustained rate is one input word per clock;
// the input stalls only while a result sits in the output register and the
// output is stalled. Bytes that cause no result (length, type, header fields,
// trailing bytes) pass at the same rate. After any status word the block
// ignores all input until reset. stream_count and max_length must be written
// while the block is idle (not enforced); register indexes 2 and 3 are ignored.
module length_prefixed_packet_deframer_core (
    input  logic                            clk,
    input  logic                            rst_n,

    input  logic                            cfg_we,
    input  logic [lpd_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [lpd_pkg::CFG_DATA_W-1:0]  cfg_data,

    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic                            kind,
    input  logic [7:0]                      data_byte,

    output logic                            out_valid,
    input  logic                            out_stall,
    output logic [1:0]                      result_kind,
    output logic [1:0]                      status,
    output logic [7:0]                      stream_id,
    output logic signed [63:0]              pts,
    output logic signed [63:0]              dts,
    output logic signed [63:0]              duration,
    output logic                            is_key,
    output logic [25:0]                     payload_size,
    output logic [7:0]                      payload_byte,
    output logic                            last
);

    lpd_pkg::cfg_t    cfg_reg;
    lpd_pkg::result_t res;
    lpd_pkg::result_t out_res_reg;
    logic             res_valid;
    logic             out_valid_reg;
    logic             in_accept;

    assign in_stall  = out_valid_reg && out_stall;
    assign in_accept = in_valid && !in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            cfg_reg.stream_count <= 8'd0;
            cfg_reg.max_length   <= lpd_pkg::LIMIT_CAP;
        end else if (cfg_we) begin
            unique case (cfg_index)
                lpd_pkg::CFG_STREAM_COUNT: cfg_reg.stream_count <= cfg_data[7:0];
                lpd_pkg::CFG_MAX_LENGTH:   cfg_reg.max_length   <= cfg_data;
                default:                   cfg_reg              <= cfg_reg;
            endcase
        end
    end

    lpd_parser u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (in_accept),
        .kind      (kind),
        .data_byte (data_byte),
        .cfg       (cfg_reg),
        .res_valid (res_valid),
        .res       (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            out_valid_reg <= 1'b0;
        end else if (res_valid) begin
            out_valid_reg <= 1'b1;
        end else if (!out_stall) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid) begin
            out_res_reg <= res;
        end
    end

    assign out_valid    = out_valid_reg;
    assign result_kind  = out_res_reg.result_kind;
    assign status       = out_res_reg.status;
    assign stream_id    = out_res_reg.stream_id;
    assign pts          = out_res_reg.pts;
    assign dts          = out_res_reg.dts;
    assign duration     = out_res_reg.duration;
    assign is_key       = out_res_reg.is_key;
    assign payload_size = out_res_reg.payload_size;
    assign payload_byte = out_res_reg.payload_byte;
    assign last         = out_res_reg.last;

endmodule

### tb/sv/tb_top.sv
`timescale 1ns / 100ps

module tb_top;

    localparam logic [lpd_pkg::CFG_INDEX_W-1:0] CFG_SPARE_2 = 2'd2;
    localparam logic [lpd_pkg::CFG_INDEX_W-1:0] CFG_SPARE_3 = 2'd3;
    localparam int HOLD_CYCLES = 300;

    typedef struct packed {
        logic       eos;
        logic [7:0] b;
    } word_t;

    typedef logic [lpd_pkg::CFG_DATA_W-1:0] cfg_word_t;

    logic                            clk       = 1'b0;
    logic                            rst_n     = 1'b0;
    logic                            cfg_we    = 1'b0;
    logic [lpd_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
    logic [lpd_pkg::CFG_DATA_W-1:0]  cfg_data  = '0;
    logic                            in_valid  = 1'b0;
    logic                            kind      = 1'b0;
    logic [7:0]                      data_byte = 8'h00;
    logic                            out_stall = 1'b0;

    logic                   in_stall;
    logic                   out_valid;
    logic [1:0]             result_kind;
    logic [1:0]             status;
    logic [7:0]             stream_id;
    logic signed [63:0]     pts;
    logic signed [63:0]     dts;
    logic signed [63:0]     duration;
    logic                   is_key;
    logic [25:0]            payload_size;
    logic [7:0]             payload_byte;
    logic                   last;

    length_prefixed_packet_deframer_core u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .kind         (kind),
        .data_byte    (data_byte),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .result_kind  (result_kind),
        .status       (status),
        .stream_id    (stream_id),
        .pts          (pts),
        .dts          (dts),
        .duration     (duration),
        .is_key       (is_key),
        .payload_size (payload_size),
        .payload_byte (payload_byte),
        .last         (last)
    );

    always #4 clk = ~clk;

    word_t            word_q[$];
    lpd_pkg::result_t expected_q[$];
    int               err_count = 0;

    // deframer shadow state
    lpd_pkg::phase_t dp_phase = lpd_pkg::PH_LEN;
    logic        dp_halted  = 1'b0;
    logic [31:0] dp_len     = '0;
    logic [31:0] dp_pos     = '0;
    logic        dp_key     = 1'b0;
    logic [7:0]  dp_sid     = '0;
    logic [63:0] dp_pts     = '0;
    logic [63:0] dp_dts     = '0;
    logic [63:0] dp_dur     = '0;
    logic [31:0] dp_size    = '0;
    logic [7:0]  reg_streams = 8'd0;
    logic [26:0] reg_limit   = lpd_pkg::LIMIT_CAP;

    logic    in_taken = 1'b0;
    word_t   tx_word;
    int      tx_gap = 0;
    int      tx_calm = 0;
    int      rx_gap = 0;
    int      rx_calm = 0;
    int      rx_hold_left = 0;
    int      rx_hold_req = 0;
    int      rx_hold_seen = 0;
    lpd_pkg::result_t head_want;

    int cur_streams = 0;
    int cur_limit = int'(lpd_pkg::LIMIT_CAP);

    function automatic int gap_len();
        if ($urandom_range(99) < 85)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic logic [63:0] rand64();
        case ($urandom_range(7))
            0: return 64'h8000_0000_0000_0000;
            1: return 64'h7FFF_FFFF_FFFF_FFFF;
            2: return 64'h0;
            3: return 64'hFFFF_FFFF_FFFF_FFFF;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("MISMATCH %s: got %0h expected %0h at %0t", what, got, want, $time);
        err_count++;
    endtask

    task automatic check_result(input lpd_pkg::result_t want);
        if (result_kind !== want.result_kind)
            report_mismatch("result_kind", 64'(result_kind), 64'(want.result_kind));
        if (status !== want.status)
            report_mismatch("status", 64'(status), 64'(want.status));
        if (stream_id !== want.stream_id)
            report_mismatch("stream_id", 64'(stream_id), 64'(want.stream_id));
        if (pts !== want.pts)
            report_mismatch("pts", pts, want.pts);
        if (dts !== want.dts)
            report_mismatch("dts", dts, want.dts);
        if (duration !== want.duration)
            report_mismatch("duration", duration, want.duration);
        if (is_key !== want.is_key)
            report_mismatch("is_key", 64'(is_key), 64'(want.is_key));
        if (payload_size !== want.payload_size)
            report_mismatch("payload_size", 64'(payload_size), 64'(want.payload_size));
        if (payload_byte !== want.payload_byte)
            report_mismatch("payload_byte", 64'(payload_byte), 64'(want.payload_byte));
        if (last !== want.last)
            report_mismatch("last", 64'(last), 64'(want.last));
    endtask

    task automatic push_status(input lpd_pkg::status_t code);
        lpd_pkg::result_t r;
        r = '0;
        r.result_kind = lpd_pkg::RK_STATUS;
        r.status = code;
        r.last = 1'b1;
        expected_q.push_back(r);
        dp_halted = 1'b1;
    endtask

    task automatic advance_byte(input logic [31:0] p);
        if (p + 32'd1 >= dp_len) begin
            dp_phase = lpd_pkg::PH_LEN;
            dp_len = '0;
            dp_pos = '0;
        end else begin
            dp_pos = p + 32'd1;
        end
    endtask

    task automatic deframe_word(input logic eos, input logic [7:0] b);
        logic [31:0]      p;
        logic [26:0]      lim;
        lpd_pkg::result_t r;
        p = dp_pos;
        if (dp_halted)
            return;
        if (eos) begin
            push_status(lpd_pkg::ST_EOS);
            return;
        end
        case (dp_phase)
            lpd_pkg::PH_LEN:
            begin
                dp_len = {dp_len[23:0], b};
                if (p < 32'd3) begin
                    dp_pos = p + 32'd1;
                end else begin
                    lim = (reg_limit > lpd_pkg::LIMIT_CAP) ? lpd_pkg::LIMIT_CAP : reg_limit;
                    if (dp_len == 32'd0 || dp_len > {5'b0, lim}) begin
                        push_status(lpd_pkg::ST_BAD_LEN);
                    end else begin
                        dp_phase = lpd_pkg::PH_TYPE;
                        dp_pos = '0;
                    end
                end
            end
            lpd_pkg::PH_TYPE:
            begin
                if (b != lpd_pkg::TYPE_PACKET && b != lpd_pkg::TYPE_KEY) begin
                    dp_phase = lpd_pkg::PH_SKIP;
                    advance_byte(p);
                end else begin
                    dp_key = (b == lpd_pkg::TYPE_KEY);
                    if (dp_len < lpd_pkg::MIN_PACKET) begin
                        if (dp_len == 32'd1) begin
                            push_status(lpd_pkg::ST_INVALID);
                        end else begin
                            dp_phase = lpd_pkg::PH_DRAIN;
                            dp_pos = p + 32'd1;
                        end
                    end else begin
                        dp_phase = lpd_pkg::PH_FIELDS;
                        dp_pos = p + 32'd1;
                    end
                end
            end
            lpd_pkg::PH_FIELDS:
            begin
                if (p == 32'd1)
                    dp_sid = b;
                else if (p <= 32'd9)
                    dp_pts = {dp_pts[55:0], b};
                else if (p <= 32'd17)
                    dp_dts = {dp_dts[55:0], b};
                else if (p <= 32'd25)
                    dp_dur = {dp_dur[55:0], b};
                else
                    dp_size = {dp_size[23:0], b};
                if (p < 32'd29) begin
                    dp_pos = p + 32'd1;
                end else if (dp_size > dp_len - lpd_pkg::MIN_PACKET
                             || dp_sid >= reg_streams) begin
                    if (dp_len == lpd_pkg::MIN_PACKET) begin
                        push_status(lpd_pkg::ST_INVALID);
                    end else begin
                        dp_phase = lpd_pkg::PH_DRAIN;
                        dp_pos = p + 32'd1;
                    end
                end else begin
                    r = '0;
                    r.result_kind = lpd_pkg::RK_HEADER;
                    r.status = lpd_pkg::ST_NONE;
                    r.stream_id = dp_sid;
                    r.pts = dp_pts;
                    r.dts = dp_dts;
                    r.duration = dp_dur;
                    r.is_key = dp_key;
                    r.payload_size = dp_size[25:0];
                    r.last = (dp_size == 32'd0);
                    expected_q.push_back(r);
                    dp_phase = (dp_size == 32'd0) ? lpd_pkg::PH_SKIP : lpd_pkg::PH_PAYLOAD;
                    advance_byte(p);
                end
            end
            lpd_pkg::PH_PAYLOAD:
            begin
                r = '0;
                r.result_kind = lpd_pkg::RK_PAYLOAD;
                r.status = lpd_pkg::ST_NONE;
                r.payload_byte = b;
                if (p - 32'd29 >= dp_size) begin
                    r.last = 1'b1;
                    dp_phase = lpd_pkg::PH_SKIP;
                end
                expected_q.push_back(r);
                advance_byte(p);
            end
            lpd_pkg::PH_DRAIN:
            begin
                if (p + 32'd1 >= dp_len)
                    push_status(lpd_pkg::ST_INVALID);
                else
                    dp_pos = p + 32'd1;
            end
            default:
            begin
                advance_byte(p);
            end
        endcase
    endtask

    always @(posedge clk) begin
        if (rst_n) begin
            if (cfg_we) begin
                case (cfg_index)
                    lpd_pkg::CFG_STREAM_COUNT: reg_streams = cfg_data[7:0];
                    lpd_pkg::CFG_MAX_LENGTH:   reg_limit = cfg_data;
                    default:                   ;
                endcase
            end
            if (out_valid && !out_stall) begin
                if (expected_q.size() == 0) begin
                    report_mismatch("unexpected result", 64'(result_kind), 64'h0);
                end else begin
                    head_want = expected_q.pop_front();
                    check_result(head_want);
                end
            end
            if (in_valid && !in_stall)
                deframe_word(kind, data_byte);
        end
        in_taken <= rst_n && in_valid && !in_stall;
    end

    // sender
    always @(negedge clk) begin
        if (in_valid && !in_taken) begin
            // stalled: hold the word
        end else if (tx_gap > 0) begin
            in_valid <= 1'b0;
            tx_gap <= tx_gap - 1;
        end else if (word_q.size() != 0) begin
            tx_word = word_q.pop_front();
            in_valid <= 1'b1;
            kind <= tx_word.eos;
            data_byte <= tx_word.b;
            if (tx_calm > 0)
                tx_calm <= tx_calm - 1;
            else if ($urandom_range(99) < 3)
                tx_calm <= $urandom_range(50, 150);
            else if ($urandom_range(99) < 30)
                tx_gap <= gap_len();
        end else begin
            in_valid <= 1'b0;
        end
    end

    // receiver
    always @(negedge clk) begin
        if (rx_hold_left > 0) begin
            out_stall <= 1'b1;
            rx_hold_left <= rx_hold_left - 1;
        end else if (rx_hold_seen != rx_hold_req) begin
            rx_hold_seen <= rx_hold_req;
            rx_hold_left <= HOLD_CYCLES;
            out_stall <= 1'b1;
        end else if (rx_gap > 0) begin
            out_stall <= 1'b1;
            rx_gap <= rx_gap - 1;
        end else begin
            out_stall <= 1'b0;
            if (rx_calm > 0)
                rx_calm <= rx_calm - 1;
            else if ($urandom_range(99) < 2)
                rx_calm <= $urandom_range(50, 150);
            else if ($urandom_range(99) < 25)
                rx_gap <= gap_len();
        end
    end

    task automatic push_word(input logic eos, input logic [7:0] b);
        word_t w;
        w.eos = eos;
        w.b = b;
        word_q.push_back(w);
    endtask

    task automatic push_byte(input logic [7:0] b);
        push_word(1'b0, b);
    endtask

    task automatic push_len(input logic [31:0] n);
        for (int i = 0; i < 4; i++)
            push_byte(n[31 - 8 * i -: 8]);
    endtask

    // message length is 30 + extra; extra bytes are payload then trailer
    task automatic push_packet(input logic key, input logic [7:0] sid, input logic [63:0] p,
                               input logic [63:0] d, input logic [63:0] u,
                               input logic [31:0] size_field, input int extra);
        push_len(32'(30 + extra));
        push_byte(key ? lpd_pkg::TYPE_KEY : lpd_pkg::TYPE_PACKET);
        push_byte(sid);
        for (int i = 0; i < 8; i++)
            push_byte(p[63 - 8 * i -: 8]);
        for (int i = 0; i < 8; i++)
            push_byte(d[63 - 8 * i -: 8]);
        for (int i = 0; i < 8; i++)
            push_byte(u[63 - 8 * i -: 8]);
        for (int i = 0; i < 4; i++)
            push_byte(size_field[31 - 8 * i -: 8]);
        repeat (extra)
            push_byte(8'($urandom_range(255)));
    endtask

    task automatic push_skip(input logic [7:0] msg_type, input int n);
        push_len(32'(n));
        push_byte(msg_type);
        repeat (n - 1)
            push_byte(8'($urandom_range(255)));
    endtask

    task automatic push_random_message();
        int         sz;
        int         extra;
        int         n;
        logic [7:0] t;
        if ($urandom_range(99) < 78) begin
            sz = ($urandom_range(9) == 0) ? $urandom_range(60) : $urandom_range(12);
            extra = sz + (($urandom_range(3) == 0) ? $urandom_range(3) : 0);
            if (30 + extra > cur_limit)
                extra = cur_limit - 30;
            if (sz > extra)
                sz = extra;
            push_packet(1'($urandom_range(1)), 8'($urandom_range(cur_streams - 1)),
                        rand64(), rand64(), rand64(), 32'(sz), extra);
        end else begin
            t = 8'($urandom_range(255));
            if (t == lpd_pkg::TYPE_PACKET || t == lpd_pkg::TYPE_KEY)
                t = t ^ 8'h40;
            n = $urandom_range(1, 40);
            if (n > cur_limit)
                n = cur_limit;
            push_skip(t, n);
        end
    endtask

    task automatic write_reg(input logic [lpd_pkg::CFG_INDEX_W-1:0] idx,
                             input logic [lpd_pkg::CFG_DATA_W-1:0] val);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic wait_idle();
        @(posedge clk);
        while (word_q.size() != 0 || in_valid || expected_q.size() != 0)
            @(posedge clk);
        repeat (4) @(negedge clk);
    endtask

    initial begin : stimulus
        int         which;
        int         n;
        int         extra;
        logic [7:0] sid;
        logic [31:0] size_field;

        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: wide stream count, full limit, spare indexes must not matter
        cur_streams = 255;
        cur_limit = int'(lpd_pkg::LIMIT_CAP);
        write_reg(lpd_pkg::CFG_STREAM_COUNT, cfg_word_t'(cur_streams));
        write_reg(lpd_pkg::CFG_MAX_LENGTH, cfg_word_t'(cur_limit));
        write_reg(CFG_SPARE_2, 27'h7FF_FFFF);
        write_reg(CFG_SPARE_3, 27'h000_0000);
        push_packet(1'b1, 8'd254, 64'h8000_0000_0000_0000, 64'h7FFF_FFFF_FFFF_FFFF,
                    64'hFFFF_FFFF_FFFF_FFFF, 32'd3, 5);
        push_packet(1'b0, 8'd0, 64'h0, 64'hFFFF_FFFF_FFFF_FFFF, 64'h1, 32'd0, 0);
        push_packet(1'b1, 8'd7, rand64(), rand64(), rand64(), 32'd0, 4);
        push_packet(1'b0, 8'd1, rand64(), rand64(), rand64(), 32'd5, 5);
        push_skip(8'h00, 1);
        push_skip(8'h01, 2);
        push_skip(8'h04, 5);
        push_skip(8'hFF, 33);
        wait_idle();

        // directed: single stream, message exactly at the length limit
        cur_streams = 1;
        cur_limit = 31;
        write_reg(lpd_pkg::CFG_STREAM_COUNT, cfg_word_t'(cur_streams));
        write_reg(lpd_pkg::CFG_MAX_LENGTH, cfg_word_t'(cur_limit));
        push_packet(1'b0, 8'd0, rand64(), rand64(), rand64(), 32'd1, 1);
        push_skip(8'h7F, 31);
        push_packet(1'b1, 8'd0, rand64(), rand64(), rand64(), 32'd0, 1);
        wait_idle();

        // directed: smallest limit, only one-byte messages fit
        cur_streams = 0;
        cur_limit = 1;
        write_reg(lpd_pkg::CFG_STREAM_COUNT, cfg_word_t'(cur_streams));
        write_reg(lpd_pkg::CFG_MAX_LENGTH, cfg_word_t'(cur_limit));
        push_skip(8'h00, 1);
        push_skip(8'h04, 1);
        push_skip(8'h80, 1);
        push_skip(8'hFF, 1);

        for (int ph = 0; ph < 5; ph++) begin
            wait_idle();
            cur_streams = (ph == 0) ? 255 : $urandom_range(1, 255);
            case (ph)
                0:       cur_limit = int'(lpd_pkg::LIMIT_CAP);
                1:       cur_limit = 27'h7FF_FFFF;
                3:       cur_limit = 93;
                default: cur_limit = $urandom_range(93, 2000);
            endcase
            write_reg(lpd_pkg::CFG_STREAM_COUNT, cfg_word_t'(cur_streams));
            write_reg(lpd_pkg::CFG_MAX_LENGTH, cfg_word_t'(cur_limit));
            if (ph == 2)
                rx_hold_req++;
            while (word_q.size() < 20)
                push_random_message();
        end
        wait_idle();

        // closing error or end of stream; the block halts after it
        which = $urandom_range(11);
        cur_streams = $urandom_range(1, 255);
        cur_limit = int'(lpd_pkg::LIMIT_CAP);
        case (which)
            4:       cur_limit = $urandom_range(1, 200);
            5, 6:    cur_limit = 27'h7FF_FFFF;
            9:       cur_streams = $urandom_range(255);
            default: ;
        endcase
        write_reg(lpd_pkg::CFG_STREAM_COUNT, cfg_word_t'(cur_streams));
        write_reg(lpd_pkg::CFG_MAX_LENGTH, cfg_word_t'(cur_limit));
        case (which)
            0:
            begin
                push_word(1'b1, 8'($urandom_range(255)));
            end
            1:
            begin
                push_byte(8'h00);
                push_byte(8'h00);
                push_word(1'b1, 8'($urandom_range(255)));
            end
            2:
            begin
                push_len(32'd40);
                push_byte(lpd_pkg::TYPE_PACKET);
                repeat ($urandom_range(1, 38))
                    push_byte(8'($urandom_range(255)));
                push_word(1'b1, 8'($urandom_range(255)));
            end
            3:       push_len(32'd0);
            4:       push_len(32'(cur_limit + 1));
            5:       push_len(32'hFFFF_FFFF);
            6:       push_len(32'(lpd_pkg::LIMIT_CAP) + 32'd1);
            7:
            begin
                push_len(32'd1);
                push_byte($urandom_range(1) ? lpd_pkg::TYPE_KEY : lpd_pkg::TYPE_PACKET);
            end
            8:
            begin
                n = $urandom_range(2, 29);
                push_len(32'(n));
                push_byte($urandom_range(1) ? lpd_pkg::TYPE_KEY : lpd_pkg::TYPE_PACKET);
                repeat (n - 1)
                    push_byte(8'($urandom_range(255)));
            end
            9:
            begin
                sid = 8'($urandom_range(255, cur_streams));
                extra = $urandom_range(5);
                push_packet(1'($urandom_range(1)), sid, rand64(), rand64(), rand64(),
                            32'($urandom_range(extra)), extra);
            end
            10:
            begin
                extra = $urandom_range(5);
                size_field = $urandom_range(1) ? 32'(extra + 1) : 32'hFFFF_FFFF;
                push_packet(1'($urandom_range(1)), 8'($urandom_range(cur_streams - 1)),
                            rand64(), rand64(), rand64(), size_field, extra);
            end
            default:
            begin
                push_packet(1'($urandom_range(1)), 8'($urandom_range(cur_streams - 1)),
                            rand64(), rand64(), rand64(), 32'd1, 0);
            end
        endcase

        // everything after the halt is ignored
        repeat (20)
            push_word(1'($urandom_range(1)), 8'($urandom_range(255)));

        wait_idle();
        repeat (10) @(negedge clk);
        if (err_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial begin
        #10_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
